// File: hw/rtl/bds_pkg.sv
// Package with shared types and constants of the bilinear RGB565 downscaler.
`default_nettype none
package bds_pkg;

    localparam int MAX_DIM   = 512;
    localparam int DIM_W     = 10;
    localparam int POS_W     = 9;
    localparam int NUM_W     = 19;
    localparam int RECIP_W   = 17;
    localparam int WGT_W     = 9;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = 5;

    localparam logic [2:0] CFG_SRC_W   = 3'd0;
    localparam logic [2:0] CFG_SRC_H   = 3'd1;
    localparam logic [2:0] CFG_DST_W   = 3'd2;
    localparam logic [2:0] CFG_DST_H   = 3'd3;
    localparam logic [2:0] CFG_X_RECIP = 3'd4;
    localparam logic [2:0] CFG_Y_RECIP = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_STORE,
        S_PLAN,
        S_WGT,
        S_CHAN,
        S_OUT,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic       store;
        logic [1:0] j;
        logic       wgt;
        logic       chan;
        logic [1:0] ch;
        logic       out_load;
        logic       last;
        logic       r;
        logic       c;
        logic       update;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic [1:0] nr;
        logic [1:0] nc;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hw/rtl/bds_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bds_div
    import bds_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DIM_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot,
    output logic [DIM_W-1:0]      o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DIM_W-1:0] r_rem;
    logic [DIM_W-1:0] r_den;
    logic [DIM_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIM_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIM_W-1:0];
            end
            r_q <= {r_q[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: hw/rtl/bds_ctrl.sv
// Controller state machine sequencing divisions, blends and result beats.
`default_nettype none
module bds_ctrl
    import bds_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_j;
    logic       r_r, r_c;
    logic [1:0] r_ch;
    logic       c_last, last_row;

    assign c_last   = ({1'b0, r_c} + 2'd1) == i_sts.nc;
    assign last_row = ({1'b0, r_r} + 2'd1) == i_sts.nr;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (i_sts.div_done) n_state = S_DIV_STORE;
            S_DIV_STORE: n_state = (r_j == 2'd3) ? S_PLAN : S_DIV_START;
            S_PLAN: begin
                if (i_sts.nr == 2'd0 || i_sts.nc == 2'd0) n_state = S_UPDATE;
                else n_state = S_WGT;
            end
            S_WGT:       n_state = S_CHAN;
            S_CHAN:      if (r_ch == CH_BLUE) n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) n_state = (c_last && last_row) ? S_UPDATE : S_WGT;
            end
            S_UPDATE:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.j         = r_j;
        o_cmd.ch        = r_ch;
        o_cmd.r         = r_r;
        o_cmd.c         = r_c;
        o_cmd.last      = c_last && last_row;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_DIV_START: o_cmd.div_start = 1'b1;
            S_DIV_STORE: o_cmd.store     = 1'b1;
            S_WGT:       o_cmd.wgt       = 1'b1;
            S_CHAN:      o_cmd.chan      = 1'b1;
            S_OUT:       o_cmd.out_load  = i_sts.out_free;
            S_UPDATE:    o_cmd.update    = 1'b1;
            default:     o_cmd           = o_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_r     <= 1'b0;
            r_c     <= 1'b0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE:      r_j <= '0;
                S_DIV_STORE: r_j <= r_j + 2'd1;
                S_PLAN: begin
                    r_r <= 1'b0;
                    r_c <= 1'b0;
                end
                S_WGT:       r_ch <= CH_RED;
                S_CHAN:      r_ch <= r_ch + 2'd1;
                S_OUT: begin
                    if (i_sts.out_free) begin
                        if (c_last) begin
                            r_c <= 1'b0;
                            r_r <= r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                default: r_j <= r_j;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bds_datapath.sv
// Datapath: configuration, position counters, line buffer, divider, blend and output register.
`default_nettype none
module bds_datapath
    import bds_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [RECIP_W-1:0] i_cfg_data,
    input  wire logic [15:0]        i_pixel,
    input  wire logic               i_frame_start,
    input  wire logic               i_out_ready,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic [47:0]             o_out_data,
    output logic                    o_out_last
);

    logic [DIM_W-1:0]   r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [RECIP_W-1:0] r_x_recip, r_y_recip;

    logic [15:0]        r_pix, r_left, r_above_left, r_up;
    logic [POS_W-1:0]   r_src_col, r_src_row;
    logic [NUM_W-1:0]   r_col_num, r_row_num;
    logic [DIM_W-1:0]   r_next_col, r_next_row;
    logic [15:0]        mem [MAX_DIM];

    logic               r_oky0, r_oky1, r_okx0, r_okx1;
    logic               r_cly0, r_cly1, r_clx0, r_clx1;
    logic [WGT_W-1:0]   r_wy0, r_wy1, r_wx0, r_wx1;
    logic [POS_W-1:0]   r_iy0, r_iy1, r_ix0, r_ix1;

    logic [16:0]        r_a00, r_a01, r_a10, r_a11;
    logic [15:0]        r_p00, r_p01, r_p10, r_p11;
    logic [POS_W-1:0]   r_oc, r_or;
    logic [7:0]         r_red, r_green, r_blue;

    logic               r_o_valid;
    logic [47:0]        r_o_data;
    logic               r_o_last;

    logic [DIM_W-1:0]   sw, sh, dw, dh;
    logic               axis_col, k;
    logic [NUM_W-1:0]   div_num;
    logic [DIM_W-1:0]   div_den, s_ax;
    logic               div_done;
    logic [NUM_W-1:0]   quot;
    logic [DIM_W-1:0]   rem;
    logic [DIM_W:0]     idx;
    logic [NUM_W:0]     q_inc, p1;
    logic               not_clamped, ok;
    logic [RECIP_W-1:0] recip;
    logic [DIM_W+RECIP_W-1:0] prod;
    logic [WGT_W-1:0]   wgt;
    logic [POS_W-1:0]   pos;
    logic [1:0]         nr, nc;
    logic [WGT_W-1:0]   wx, wy, iwx, iwy;
    logic               xc, yc;
    logic [7:0]         c00, c01, c10, c11;
    logic [25:0]        acc;
    logic [DIM_W-1:0]   col_inc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) res = DIM_W'(1);
        else if (v > hi) res = hi;
        return res;
    endfunction

    function automatic logic [7:0] chan_of(input logic [15:0] p, input logic [1:0] ch);
        logic [7:0] res;
        case (ch)
            CH_RED:   res = {p[15:11], 3'b000};
            CH_GREEN: res = {p[10:5], 2'b00};
            CH_BLUE:  res = {p[4:0], 3'b000};
            default:  res = '0;
        endcase
        return res;
    endfunction

    assign sw = clamp_dim(r_src_w, DIM_W'(MAX_DIM));
    assign sh = clamp_dim(r_src_h, DIM_W'(MAX_DIM));
    assign dw = clamp_dim(r_dst_w, sw);
    assign dh = clamp_dim(r_dst_h, sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= DIM_W'(320);
            r_src_h   <= DIM_W'(240);
            r_dst_w   <= DIM_W'(96);
            r_dst_h   <= DIM_W'(96);
            r_x_recip <= RECIP_W'(683);
            r_y_recip <= RECIP_W'(683);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_W:   r_src_w   <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_H:   r_src_h   <= i_cfg_data[DIM_W-1:0];
                CFG_DST_W:   r_dst_w   <= i_cfg_data[DIM_W-1:0];
                CFG_DST_H:   r_dst_h   <= i_cfg_data[DIM_W-1:0];
                CFG_X_RECIP: r_x_recip <= i_cfg_data;
                CFG_Y_RECIP: r_y_recip <= i_cfg_data;
                default:     r_src_w   <= r_src_w;
            endcase
        end
    end

    assign axis_col = i_cmd.j[1];
    assign k        = i_cmd.j[0];
    assign s_ax     = axis_col ? sw : sh;
    assign div_den  = axis_col ? dw : dh;
    assign div_num  = (axis_col ? r_col_num : r_row_num)
                    + (k ? NUM_W'(s_ax) : NUM_W'(0));

    bds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    assign idx         = {1'b0, axis_col ? r_next_col : r_next_row} + {{DIM_W{1'b0}}, k};
    assign q_inc       = {1'b0, quot} + (NUM_W+1)'(1);
    assign not_clamped = q_inc < (NUM_W+1)'(s_ax);
    assign p1          = not_clamped ? q_inc : {1'b0, quot};
    assign pos         = axis_col ? r_src_col : r_src_row;
    assign ok          = (idx < {1'b0, div_den}) && (p1 == (NUM_W+1)'(pos));
    assign recip       = axis_col ? r_x_recip : r_y_recip;
    assign prod        = rem * recip;
    assign wgt         = (prod[DIM_W+RECIP_W-1:8] > (DIM_W+RECIP_W-8)'(256))
                       ? WGT_W'(256) : prod[WGT_W-1+8:8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_cmd.j)
                2'd0: begin
                    r_oky0 <= ok; r_cly0 <= !not_clamped; r_wy0 <= wgt;
                    r_iy0  <= idx[POS_W-1:0];
                end
                2'd1: begin
                    r_oky1 <= ok; r_cly1 <= !not_clamped; r_wy1 <= wgt;
                    r_iy1  <= idx[POS_W-1:0];
                end
                2'd2: begin
                    r_okx0 <= ok; r_clx0 <= !not_clamped; r_wx0 <= wgt;
                    r_ix0  <= idx[POS_W-1:0];
                end
                default: begin
                    r_okx1 <= ok; r_clx1 <= !not_clamped; r_wx1 <= wgt;
                    r_ix1  <= idx[POS_W-1:0];
                end
            endcase
        end
    end

    assign nr = r_oky0 ? (r_oky1 ? 2'd2 : 2'd1) : 2'd0;
    assign nc = r_okx0 ? (r_okx1 ? 2'd2 : 2'd1) : 2'd0;

    assign wx  = i_cmd.c ? r_wx1 : r_wx0;
    assign wy  = i_cmd.r ? r_wy1 : r_wy0;
    assign xc  = i_cmd.c ? r_clx1 : r_clx0;
    assign yc  = i_cmd.r ? r_cly1 : r_cly0;
    assign iwx = WGT_W'(256) - wx;
    assign iwy = WGT_W'(256) - wy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt) begin
            r_a00 <= 17'(iwx * iwy);
            r_a01 <= 17'(wx * iwy);
            r_a10 <= 17'(iwx * wy);
            r_a11 <= 17'(wx * wy);
            r_p11 <= r_pix;
            r_p10 <= xc ? r_pix : r_left;
            r_p01 <= yc ? r_pix : r_up;
            r_p00 <= yc ? (xc ? r_pix : r_left) : (xc ? r_up : r_above_left);
            r_oc  <= i_cmd.c ? r_ix1 : r_ix0;
            r_or  <= i_cmd.r ? r_iy1 : r_iy0;
        end
    end

    assign c00 = chan_of(r_p00, i_cmd.ch);
    assign c01 = chan_of(r_p01, i_cmd.ch);
    assign c10 = chan_of(r_p10, i_cmd.ch);
    assign c11 = chan_of(r_p11, i_cmd.ch);
    assign acc = 26'(c00 * r_a00) + 26'(c01 * r_a01) + 26'(c10 * r_a10)
               + 26'(c11 * r_a11) + 26'(32768);

    always_ff @(posedge i_clk) begin
        if (i_cmd.chan) begin
            case (i_cmd.ch)
                CH_RED:   r_red   <= acc[23:16];
                CH_GREEN: r_green <= acc[23:16];
                default:  r_blue  <= acc[23:16];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_data <= {6'b0, r_or, r_oc, r_blue, r_green, r_red};
            r_o_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_up <= mem[i_frame_start ? POS_W'(0) : r_src_col];
        end
        if (i_cmd.update) begin
            mem[r_src_col] <= r_pix;
        end
    end

    assign col_inc = (nc == 2'd2) ? DIM_W'(sw << 1) : ((nc == 2'd1) ? sw : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_above_left <= '0;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_col_num    <= '0;
            r_next_col   <= '0;
            r_row_num    <= '0;
            r_next_row   <= '0;
        end else if (i_cmd.accept) begin
            if (i_frame_start) begin
                r_src_col  <= '0;
                r_src_row  <= '0;
                r_col_num  <= '0;
                r_next_col <= '0;
                r_row_num  <= '0;
                r_next_row <= '0;
            end
        end else if (i_cmd.update) begin
            r_above_left <= r_up;
            r_left       <= r_pix;
            if (({1'b0, r_src_col} + DIM_W'(1)) >= sw) begin
                r_src_col  <= '0;
                r_next_col <= '0;
                r_col_num  <= '0;
                if (({1'b0, r_src_row} + DIM_W'(1)) >= sh) begin
                    r_src_row  <= '0;
                    r_next_row <= '0;
                    r_row_num  <= '0;
                end else begin
                    r_src_row  <= r_src_row + 1'b1;
                    r_next_row <= r_next_row + DIM_W'(nr);
                    r_row_num  <= r_row_num + ((nr == 2'd2) ? NUM_W'({sh, 1'b0})
                                : ((nr == 2'd1) ? NUM_W'(sh) : NUM_W'(0)));
                end
            end else begin
                r_src_col  <= r_src_col + 1'b1;
                r_next_col <= r_next_col + DIM_W'(nc);
                r_col_num  <= r_col_num + NUM_W'(col_inc)
                            + ((nc == 2'd2 && sw[DIM_W-1]) ? NUM_W'(1 << DIM_W) : NUM_W'(0));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.nr       = nr;
    assign o_sts.nc       = nc;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_last  = r_o_last;

endmodule
`default_nettype wire

// File: hw/rtl/bilinear_rgb565_downscaler.sv
// Top level of the bilinear RGB565 to RGB888 downscaler.
//
// Source pixels enter in raster order on the slave stream: tdata carries the
// RGB565 pixel and tuser marks the first pixel of a frame, which clears the
// position counters. Destination pixels leave on the master stream, with
// tlast set on the last result that one source pixel causes.
// Sizes and reciprocals are written through the configuration channel, which
// is always ready; write it only while the block is idle.
// One source beat runs four position divisions on a shared serial divider (one
// quotient bit per cycle), a planning step, and then for each of its up to four
// results a weight step, one step per colour channel and an output load.
// The result register holds a beat while the receiver stalls; the block then
// waits before loading the next result and accepts no source beat.
// Reset restores the default configuration and clears the counters; the line
// buffer is not cleared and only entries written by pixels are read.
`default_nettype none
module bilinear_rgb565_downscaler
    import bds_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [RECIP_W-1:0] i_cfg_data,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [15:0]        i_s_axis_tdata,  // pixel[15:0]
    input  wire logic               i_s_axis_tuser,  // frame_start
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [47:0]             o_m_axis_tdata,  // red, green, blue, out_col, out_row, zeros
    output logic                    o_m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bds_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_s_axis_tdata),
        .i_frame_start (i_s_axis_tuser),
        .i_out_ready   (i_m_axis_tready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
